// File: hdl/extent_run_record_decoder_unit_defines.svh
// Assertion macros shared by the extent record decoder RTL.
`ifndef EXTENT_RUN_RECORD_DECODER_UNIT_DEFINES_SVH
`define EXTENT_RUN_RECORD_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH

// Antecedent true in a cycle implies consequent true in the same cycle.
`define ERD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: consequent false when antecedent held");

// Antecedent true in a cycle implies consequent true in the next cycle.
`define ERD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: consequent false one cycle after antecedent");

`else

`define ERD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ERD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/erd_pkg.sv
// Types, constants and helper functions of the extent record decoder.
`timescale 1ns / 1ps

package erd_pkg;

  // Largest size code that fits the 64-bit start block and count fields.
  localparam logic [2:0] MAX_SIZE_CODE = 3'd4;

  // Width of the packed output data word, padded to whole bytes.
  localparam int unsigned OUT_DATA_W = 168;

  // Parse phase, one-hot.
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_BLOCK  = 4'b0010,
    PH_COUNT  = 4'b0100,
    PH_LENGTH = 4'b1000
  } phase_t;

  // One decoded result.
  typedef struct packed {
    logic        bad_format;
    logic        end_of_list;
    logic [4:0]  record_bytes;
    logic [31:0] indirect_length;
    logic [63:0] block_count;
    logic [63:0] start_block;
  } result_t;

  // Number of field bytes that a size code announces; zero when absent.
  function automatic logic [3:0] bytes_for_code(input logic [2:0] code);
    logic [3:0] n;
    begin
      case (code)
        3'd1:    n = 4'd1;
        3'd2:    n = 4'd2;
        3'd3:    n = 4'd4;
        3'd4:    n = 4'd8;
        default: n = 4'd0;
      endcase
      return n;
    end
  endfunction

endpackage

// File: hdl/erd_parser.sv
// Record parser: holds the parse state and decodes one byte per strobe.
`timescale 1ns / 1ps

module erd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_take,    // consume data_byte at this edge
  input  logic [7:0]       data_byte,
  output logic             result_valid, // data_byte would complete a result
  output erd_pkg::result_t result
);
  import erd_pkg::*;

  phase_t      parse_phase, parse_phase_next;
  logic [3:0]  bytes_remaining, bytes_remaining_next;
  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  saved_header, saved_header_next;
  logic [63:0] block_acc, block_acc_next;
  logic [63:0] count_acc, count_acc_next;
  logic [31:0] length_acc, length_acc_next;
  logic [4:0]  record_length, record_length_next;

  logic [2:0]  hdr_bc, hdr_nc, hdr_lc;
  logic [2:0]  sav_nc, sav_lc;
  logic [63:0] block_merged, count_merged;
  logic [31:0] length_merged;
  logic [4:0]  length_inc;
  logic [3:0]  remaining_dec;

  assign hdr_bc = data_byte[2:0];
  assign hdr_nc = data_byte[5:3];
  assign hdr_lc = {1'b0, data_byte[7:6]};
  assign sav_nc = saved_header[5:3];
  assign sav_lc = {1'b0, saved_header[7:6]};

  // The incoming byte merged into the lane of the field being collected.
  always_comb begin
    block_merged  = block_acc;
    count_merged  = count_acc;
    length_merged = length_acc;
    for (int i = 0; i < 8; i++) begin
      if (byte_position == i[2:0]) begin
        if (parse_phase == PH_BLOCK) block_merged[i*8 +: 8] = data_byte;
        if (parse_phase == PH_COUNT) count_merged[i*8 +: 8] = data_byte;
      end
    end
    for (int j = 0; j < 4; j++) begin
      if (byte_position[1:0] == j[1:0] && parse_phase == PH_LENGTH) begin
        length_merged[j*8 +: 8] = data_byte;
      end
    end
  end

  assign length_inc    = record_length + 5'd1;
  assign remaining_dec = bytes_remaining - 4'd1;

  // Next state and result for the byte on data_byte.
  always_comb begin
    parse_phase_next     = parse_phase;
    bytes_remaining_next = bytes_remaining;
    byte_position_next   = byte_position;
    saved_header_next    = saved_header;
    block_acc_next       = block_acc;
    count_acc_next       = count_acc;
    length_acc_next      = length_acc;
    record_length_next   = record_length;
    result_valid         = 1'b0;
    result               = '0;
    case (parse_phase)
      PH_HEADER: begin
        if (data_byte == 8'd0) begin
          result_valid       = 1'b1;
          result.end_of_list = 1'b1;
        end else if (hdr_bc > MAX_SIZE_CODE || hdr_nc > MAX_SIZE_CODE) begin
          result_valid        = 1'b1;
          result.bad_format   = 1'b1;
          result.record_bytes = 5'd1;
        end else begin
          saved_header_next  = data_byte;
          block_acc_next     = '0;
          count_acc_next     = (hdr_nc == 3'd0) ? 64'd1 : 64'd0;
          length_acc_next    = '0;
          record_length_next = 5'd1;
          byte_position_next = 3'd0;
          if (hdr_bc != 3'd0) begin
            parse_phase_next     = PH_BLOCK;
            bytes_remaining_next = bytes_for_code(hdr_bc);
          end else if (hdr_nc != 3'd0) begin
            parse_phase_next     = PH_COUNT;
            bytes_remaining_next = bytes_for_code(hdr_nc);
          end else if (hdr_lc != 3'd0) begin
            parse_phase_next     = PH_LENGTH;
            bytes_remaining_next = bytes_for_code(hdr_lc);
          end else begin
            // Header with every field absent: the record is complete.
            result_valid        = 1'b1;
            result.block_count  = 64'd1;
            result.record_bytes = 5'd1;
          end
        end
      end
      PH_BLOCK, PH_COUNT, PH_LENGTH: begin
        block_acc_next     = block_merged;
        count_acc_next     = count_merged;
        length_acc_next    = length_merged;
        record_length_next = length_inc;
        if (remaining_dec != 4'd0) begin
          bytes_remaining_next = remaining_dec;
          byte_position_next   = byte_position + 3'd1;
        end else begin
          byte_position_next = 3'd0;
          if (parse_phase == PH_BLOCK && sav_nc != 3'd0) begin
            parse_phase_next     = PH_COUNT;
            bytes_remaining_next = bytes_for_code(sav_nc);
          end else if (parse_phase != PH_LENGTH && sav_lc != 3'd0) begin
            parse_phase_next     = PH_LENGTH;
            bytes_remaining_next = bytes_for_code(sav_lc);
          end else begin
            // Last present field finished: hand out the record.
            parse_phase_next       = PH_HEADER;
            bytes_remaining_next   = 4'd0;
            result_valid           = 1'b1;
            result.start_block     = block_merged;
            result.block_count     = count_merged;
            result.indirect_length = length_merged;
            result.record_bytes    = length_inc;
          end
        end
      end
      default: begin
        parse_phase_next     = PH_HEADER;
        bytes_remaining_next = 4'd0;
        byte_position_next   = 3'd0;
      end
    endcase
  end

  // Control state under reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_HEADER;
      bytes_remaining <= 4'd0;
      byte_position   <= 3'd0;
    end else if (byte_take) begin
      parse_phase     <= parse_phase_next;
      bytes_remaining <= bytes_remaining_next;
      byte_position   <= byte_position_next;
    end
  end

  // Record payload, always set up by a header before it is read.
  always_ff @(posedge clk) begin
    if (byte_take) begin
      saved_header  <= saved_header_next;
      block_acc     <= block_acc_next;
      count_acc     <= count_acc_next;
      length_acc    <= length_acc_next;
      record_length <= record_length_next;
    end
  end

endmodule

// File: hdl/extent_run_record_decoder_unit.sv
// Extent record decoder: splits a byte stream of packed extent records into results.
//
// Input: one byte of the packed extent list per beat on s_tdata. Each record
// is a header byte followed by up to three little-endian fields.
// Output: one beat per record, per zero header (end of list) and per header
// with an oversized start-block or count size code (bad format). Flags travel
// on m_tuser, decoded fields on m_tdata.
// Throughput: one input beat per cycle unless a completed result is held up at
// the output, since each byte only lands in one lane of an accumulator. A result
// passes through the input register and then the result register before it
// leaves.
// Stalls: a result waiting in the result register still lets bytes that
// complete no result be taken; a byte that would complete another result
// waits in the input register, and s_tready drops only once that register is
// full and cannot drain.
// Reset (rst, synchronous): both registers empty, the parser expects a header.
`timescale 1ns / 1ps

`include "extent_run_record_decoder_unit_defines.svh"

module extent_run_record_decoder_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata,   // [63:0] start_block, [127:64] block_count,
                                  // [159:128] indirect_length, [164:160] record_bytes,
                                  // [167:165] zero
  output logic [1:0]   m_tuser    // [0] end_of_list, [1] bad_format
);
  import erd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  result_t    out_result;

  logic       out_free;
  logic       consume;
  logic       parse_valid;
  result_t    parse_result;

  erd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .byte_take    (consume),
    .data_byte    (in_byte),
    .result_valid (parse_valid),
    .result       (parse_result)
  );

  // A byte may leave the input register unless its result has nowhere to go.
  assign out_free = !out_valid || m_tready;
  assign consume  = in_valid && (!parse_valid || out_free);
  assign s_tready = !in_valid || consume;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && parse_valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && parse_valid) begin
      out_result <= parse_result;
    end
  end

  // Output packing.
  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_result.record_bytes, out_result.indirect_length,
                     out_result.block_count, out_result.start_block};
  assign m_tuser  = {out_result.bad_format, out_result.end_of_list};

  // Checks on the results handed out.
  `ERD_ASSERT_IMPLIES(a_flags_exclusive, clk, rst,
    m_tvalid, !(m_tuser[0] && m_tuser[1]))
  `ERD_ASSERT_IMPLIES(a_eol_empty, clk, rst,
    m_tvalid && m_tuser[0], m_tdata == '0)
  `ERD_ASSERT_IMPLIES(a_bad_one_byte, clk, rst,
    m_tvalid && m_tuser[1], m_tdata[164:160] == 5'd1 && m_tdata[159:0] == '0)
  `ERD_ASSERT_IMPLIES(a_record_nonempty, clk, rst,
    m_tvalid && !m_tuser[0], m_tdata[164:160] != 5'd0)
  `ERD_ASSERT_NEXT(a_stalled_result_kept, clk, rst,
    m_tvalid && !m_tready, m_tvalid)

endmodule

// File: dv/tb.sv
// Self-checking testbench of the extent run record decoder unit.
`timescale 1ns / 1ps

module tb;
  import erd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 615;
  localparam int STEADY_BYTES   = 150;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;    // [7:0] data_byte
  logic         m_tvalid;
  logic         m_tready;
  logic [167:0] m_tdata;    // [63:0] start_block, [127:64] block_count,
                            // [159:128] indirect_length, [164:160] record_bytes
  logic [1:0]   m_tuser;    // [0] end_of_list, [1] bad_format

  extent_run_record_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Decoded records still owed by the block, oldest first.
  result_t pending_results[$];

  // Own copy of the parser state.
  logic [3:0]  parse_phase;
  logic [3:0]  owed_bytes;
  logic [2:0]  lane;
  logic [7:0]  header;
  logic [63:0] start_acc;
  logic [63:0] count_acc;
  logic [31:0] length_acc;
  logic [4:0]  record_len;

  int  mismatches;
  int  bytes_sent;
  int  idle_cycles;
  bit  steady;
  int  hold_request;
  int  hold_left;

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Byte count of a field with the given size code; zero when absent.
  function automatic logic [3:0] field_bytes(input logic [2:0] code);
    if (code == 3'd0) begin
      return 4'd0;
    end
    return 4'd1 << ((code - 3'd1) & 3'd3);
  endfunction

  // Size code of the field that a phase collects.
  function automatic logic [2:0] code_of(input logic [3:0] p);
    case (p)
      PH_BLOCK: begin
        return header[2:0];
      end
      PH_COUNT: begin
        return header[5:3];
      end
      default: begin
        return {1'b0, header[7:6]};
      end
    endcase
  endfunction

  // Moves to the first present field from the given phase on; false if none is left.
  function automatic bit advance_field(input logic [3:0] first);
    logic [3:0] p;
    logic [3:0] n;
    for (p = first; p != 4'd0; p = p << 1) begin
      n = field_bytes(code_of(p));
      if (n != 4'd0) begin
        parse_phase = p;
        owed_bytes  = n;
        lane        = 3'd0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Record completed from the accumulators.
  function automatic result_t finished_record();
    result_t r;
    r                 = '0;
    r.start_block     = start_acc;
    r.block_count     = count_acc;
    r.indirect_length = length_acc;
    r.record_bytes    = record_len;
    return r;
  endfunction

  // Advances the parser by one byte and queues the result it completes, if any.
  task automatic decode_byte(input logic [7:0] b);
    result_t     r;
    logic [63:0] v;
    r = '0;
    if (parse_phase == PH_HEADER) begin
      if (b == 8'd0) begin
        r.end_of_list = 1'b1;
        pending_results.push_back(r);
      end else if (b[2:0] > MAX_SIZE_CODE || b[5:3] > MAX_SIZE_CODE) begin
        r.bad_format   = 1'b1;
        r.record_bytes = 5'd1;
        pending_results.push_back(r);
      end else begin
        header     = b;
        start_acc  = '0;
        count_acc  = (b[5:3] == 3'd0) ? 64'd1 : 64'd0;
        length_acc = '0;
        record_len = 5'd1;
        if (!advance_field(PH_BLOCK)) begin
          pending_results.push_back(finished_record());
          parse_phase = PH_HEADER;
        end
      end
    end else begin
      if (owed_bytes != 4'd0) begin
        v          = {56'd0, b} << {lane, 3'b000};
        record_len = record_len + 5'd1;
        case (parse_phase)
          PH_BLOCK: begin
            start_acc = start_acc | v;
          end
          PH_COUNT: begin
            count_acc = count_acc | v;
          end
          default: begin
            length_acc = length_acc | v[31:0];
          end
        endcase
        lane       = lane + 3'd1;
        owed_bytes = owed_bytes - 4'd1;
      end
      if (owed_bytes == 4'd0 && !advance_field(parse_phase << 1)) begin
        pending_results.push_back(finished_record());
        parse_phase = PH_HEADER;
        lane        = 3'd0;
      end
    end
  endtask

  // Prints one mismatch and counts it.
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Every accepted input beat feeds the predictor.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      decode_byte(s_tdata);
    end
  end

  // Every accepted output beat is compared with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no record expected");
      end else begin
        want = pending_results.pop_front();
        check_field("start_block", m_tdata[63:0], want.start_block);
        check_field("block_count", m_tdata[127:64], want.block_count);
        check_field("indirect_length", {32'd0, m_tdata[159:128]},
                    {32'd0, want.indirect_length});
        check_field("record_bytes", {59'd0, m_tdata[164:160]}, {59'd0, want.record_bytes});
        check_field("end_of_list", {63'd0, m_tuser[0]}, {63'd0, want.end_of_list});
        check_field("bad_format", {63'd0, m_tuser[1]}, {63'd0, want.bad_format});
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 28);
    end
  end

  // Offers one byte, at times with a random gap before it, and waits until it is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 28) begin
      gap = $urandom_range(1, 2);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // Sends a header and the field bytes it announces.
  // fill: 0 random bytes, 1 all ones, 2 all zeros.
  task automatic send_record(input logic [7:0] hdr, input int fill);
    int n;
    send_byte(hdr);
    if (hdr == 8'd0 || hdr[2:0] > MAX_SIZE_CODE || hdr[5:3] > MAX_SIZE_CODE) begin
      return;
    end
    n = int'(field_bytes(hdr[2:0])) + int'(field_bytes(hdr[5:3]))
        + int'(field_bytes({1'b0, hdr[7:6]}));
    repeat (n) begin
      case (fill)
        1: send_byte(8'hFF);
        2: send_byte(8'h00);
        default: send_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  // End of list, oversized codes, each field alone and a start block with a count.
  task automatic test_special_headers();
    send_record(8'h00, 0);
    send_record(8'h05, 0);
    send_record(8'h28, 0);
    send_record(8'hFF, 0);
    send_record(8'h01, 1);
    send_record(8'h08, 1);
    send_record(8'h40, 0);
    send_record(8'h09, 2);
  endtask

  // Widest record: eight-byte start block and count, four-byte length.
  task automatic test_longest_record();
    send_record(8'hE4, 1);
    send_record(8'hE4, 2);
  endtask

  // Mostly well-formed records with random content, the rest noise.
  task automatic test_random_stream();
    int          first;
    int          pick;
    logic [2:0]  bc;
    logic [2:0]  nc;
    logic [1:0]  lc;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      // A stretch at the start runs with no idling on either side.
      steady = (bytes_sent - first < STEADY_BYTES);
      pick   = $urandom_range(99);
      if (pick < 80) begin
        bc = 3'($urandom_range(4));
        nc = 3'($urandom_range(4));
        lc = 2'($urandom_range(3));
        if ({lc, nc, bc} == 8'd0) begin
          bc = 3'd1;
        end
        pick = $urandom_range(19);
        send_record({lc, nc, bc}, (pick == 0) ? 1 : (pick == 1) ? 2 : 0);
      end else if (pick < 85) begin
        send_byte(8'h00);
      end else if (pick < 90) begin
        bc = 3'($urandom_range(7));
        nc = 3'($urandom_range(5, 7));
        lc = 2'($urandom_range(3));
        send_byte($urandom_range(1) ? {lc, nc, bc} : {lc, bc, nc});
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
    steady = 1'b0;
  endtask

  // The receiver stalls for a long stretch while short records keep coming.
  task automatic test_output_hold_off();
    steady       = 1'b1;
    hold_request = 300;
    repeat (40) begin
      send_record(8'h01, 0);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'd0;
    m_tready     = 1'b0;
    mismatches   = 0;
    bytes_sent   = 0;
    idle_cycles  = 0;
    steady       = 1'b0;
    hold_request = 0;
    hold_left    = 0;
    parse_phase  = PH_HEADER;
    owed_bytes   = '0;
    lane         = '0;
    header       = '0;
    start_acc    = '0;
    count_acc    = '0;
    length_acc   = '0;
    record_len   = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_special_headers();
    test_longest_record();
    test_output_hold_off();
    test_random_stream();

    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain; the watchdog bounds this wait.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (pending_results.size() != 0) begin
      report_mismatch("records still expected at the end of the run");
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
